>>> src/tbat_pkg.sv
// Package for the thermistor block averager: shared types, the calibration ROM
// and fixed constants. It has no dependencies.
`timescale 1ns / 1ps

package tbat_pkg;

    localparam int unsigned RomHeld   = 141;
    localparam int unsigned BlockLen  = 10;
    localparam int unsigned TempBase  = 300;
    localparam int unsigned SumW      = 16;
    localparam int unsigned SampleW   = 12;
    localparam int unsigned TempW     = 9;
    localparam int unsigned LimitW    = 10;
    localparam int unsigned CountW    = 4;

    localparam logic REG_SHOW_LOW  = 1'b0;
    localparam logic REG_SHOW_HIGH = 1'b1;

    localparam logic [15:0] CAL_ROM [0:RomHeld-1] = '{
        16'd1580,  16'd1857,  16'd2134,  16'd2411,  16'd2688,
        16'd2965,  16'd3242,  16'd3519,  16'd3796,  16'd4073,
        16'd4350,  16'd4627,  16'd4904,  16'd5181,  16'd5458,
        16'd5735,  16'd6012,  16'd6289,  16'd6566,  16'd6843,
        16'd7120,  16'd7396,  16'd7672,  16'd7948,  16'd8224,
        16'd8500,  16'd8776,  16'd9052,  16'd9328,  16'd9604,
        16'd9880,  16'd10156, 16'd10432, 16'd10708, 16'd10984,
        16'd11260, 16'd11536, 16'd11812, 16'd12088, 16'd12364,
        16'd12640, 16'd12915, 16'd13190, 16'd13465, 16'd13740,
        16'd14015, 16'd14290, 16'd14565, 16'd14840, 16'd15115,
        16'd15390, 16'd15664, 16'd15938, 16'd16212, 16'd16486,
        16'd16760, 16'd17034, 16'd17308, 16'd17582, 16'd17856,
        16'd18130, 16'd18403, 16'd18676, 16'd18949, 16'd19222,
        16'd19495, 16'd19768, 16'd20041, 16'd20314, 16'd20587,
        16'd20860, 16'd21131, 16'd21402, 16'd21673, 16'd21944,
        16'd22215, 16'd22486, 16'd22757, 16'd23028, 16'd23299,
        16'd23570, 16'd23839, 16'd24108, 16'd24377, 16'd24646,
        16'd24915, 16'd25184, 16'd25453, 16'd25722, 16'd25991,
        16'd26260, 16'd26527, 16'd26794, 16'd27061, 16'd27328,
        16'd27595, 16'd27862, 16'd28129, 16'd28396, 16'd28663,
        16'd28930, 16'd29195, 16'd29460, 16'd29725, 16'd29990,
        16'd30255, 16'd30520, 16'd30785, 16'd31050, 16'd31315,
        16'd31580, 16'd31843, 16'd32106, 16'd32369, 16'd32632,
        16'd32895, 16'd33158, 16'd33421, 16'd33684, 16'd33947,
        16'd34210, 16'd34470, 16'd34730, 16'd34990, 16'd35250,
        16'd35510, 16'd35770, 16'd36030, 16'd36290, 16'd36550,
        16'd36810, 16'd37068, 16'd37326, 16'd37584, 16'd37842,
        16'd38100, 16'd38358, 16'd38616, 16'd38874, 16'd39132,
        16'd39390
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } tbat_state_t;

    typedef struct packed {
        logic accept;
        logic block_end;
        logic scan_step;
        logic emit;
    } tbat_cmd_t;

    typedef struct packed {
        logic last_sample;
        logic scan_last;
    } tbat_status_t;

endpackage

>>> src/tbat_ctrl.sv
// Controller for the thermistor block averager: sequences sample intake,
// the ROM scan and the result strobe. Depends on tbat_pkg.
`timescale 1ns / 1ps

module tbat_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tbat_pkg::tbat_status_t status,
    output logic                busy,
    output tbat_pkg::tbat_cmd_t cmd
);

    tbat_pkg::tbat_state_t state_reg;
    tbat_pkg::tbat_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbat_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbat_pkg::S_IDLE:
            begin
                if (start && status.last_sample)
                begin
                    state_next = tbat_pkg::S_SCAN;
                end
            end
            tbat_pkg::S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = tbat_pkg::S_OUT;
                end
            end
            tbat_pkg::S_OUT:
            begin
                state_next = tbat_pkg::S_IDLE;
            end
            default:
            begin
                state_next = tbat_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy          = 1'b1;
        cmd.accept    = 1'b0;
        cmd.block_end = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            tbat_pkg::S_IDLE:
            begin
                busy          = 1'b0;
                cmd.accept    = start;
                cmd.block_end = start && status.last_sample;
            end
            tbat_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            tbat_pkg::S_OUT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> src/tbat_datapath.sv
// Datapath for the thermistor block averager: sample accumulator, nearest-entry
// ROM scan, limit registers and result registers. Depends on tbat_pkg.
`timescale 1ns / 1ps

module tbat_datapath
#(
    parameter int unsigned TABLE_ENTRIES = 141
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tbat_pkg::tbat_cmd_t               cmd,
    output tbat_pkg::tbat_status_t            status,
    input  logic [tbat_pkg::SampleW-1:0]      adc_sample,
    input  logic                              cfg_wr,
    input  logic                              cfg_index,
    input  logic [tbat_pkg::LimitW-1:0]       cfg_data,
    output logic                              done,
    output logic [tbat_pkg::SumW-1:0]         block_sum,
    output logic [tbat_pkg::TempW-1:0]        temp_tenths,
    output logic                              in_table,
    output logic                              shown
);

    localparam int unsigned TableLen =
        (TABLE_ENTRIES > tbat_pkg::RomHeld) ? tbat_pkg::RomHeld : TABLE_ENTRIES;
    localparam int unsigned IdxW = (TableLen > 1) ? $clog2(TableLen) : 1;
    localparam logic [IdxW-1:0] IdxLast = IdxW'(TableLen - 1);
    localparam logic [tbat_pkg::CountW-1:0] CountLast =
        tbat_pkg::CountW'(tbat_pkg::BlockLen - 1);
    localparam logic [15:0] RomFirst = tbat_pkg::CAL_ROM[0];
    localparam logic [15:0] RomLast  = tbat_pkg::CAL_ROM[TableLen-1];

    logic [tbat_pkg::CountW-1:0]  count_reg;
    logic [tbat_pkg::SumW-1:0]    sum_reg;
    logic [tbat_pkg::SumW-1:0]    sum_next;
    logic [tbat_pkg::SumW-1:0]    blk_sum_reg;
    logic [IdxW-1:0]              idx_reg;
    logic [IdxW-1:0]              best_idx_reg;
    logic [tbat_pkg::SumW:0]      best_diff_reg;
    logic [tbat_pkg::LimitW-1:0]  low_reg;
    logic [tbat_pkg::LimitW-1:0]  high_reg;
    logic                         done_reg;
    logic [tbat_pkg::SumW-1:0]    out_sum_reg;
    logic [tbat_pkg::TempW-1:0]   out_temp_reg;
    logic                         out_in_reg;
    logic                         out_shown_reg;

    logic [15:0]                  rom_val;
    logic [tbat_pkg::SumW-1:0]    diff;
    logic                         range_ok;
    logic [tbat_pkg::TempW-1:0]   temp_calc;
    logic                         show_calc;

    assign sum_next = sum_reg + tbat_pkg::SumW'(adc_sample);
    assign status.last_sample = (count_reg == CountLast);
    assign status.scan_last   = (idx_reg == IdxLast);

    assign rom_val = tbat_pkg::CAL_ROM[8'(idx_reg)];
    assign diff = (blk_sum_reg >= rom_val) ? (blk_sum_reg - rom_val)
                                           : (rom_val - blk_sum_reg);

    assign range_ok  = (blk_sum_reg >= RomFirst) && (blk_sum_reg <= RomLast);
    assign temp_calc = range_ok ? tbat_pkg::TempW'(tbat_pkg::TempBase + 32'(best_idx_reg))
                                : '0;
    assign show_calc = range_ok
                    && (tbat_pkg::LimitW'(temp_calc) > low_reg)
                    && (tbat_pkg::LimitW'(temp_calc) < high_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            low_reg   <= tbat_pkg::LimitW'(320);
            high_reg  <= tbat_pkg::LimitW'(420);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.accept)
            begin
                if (cmd.block_end)
                begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                end
                else
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_next;
                end
            end
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    tbat_pkg::REG_SHOW_LOW:  low_reg  <= cfg_data;
                    tbat_pkg::REG_SHOW_HIGH: high_reg <= cfg_data;
                    default:                 low_reg  <= low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.block_end)
        begin
            blk_sum_reg   <= sum_next;
            idx_reg       <= '0;
            best_idx_reg  <= '0;
            best_diff_reg <= '1;
        end
        else if (cmd.scan_step)
        begin
            if ({1'b0, diff} < best_diff_reg)
            begin
                best_diff_reg <= {1'b0, diff};
                best_idx_reg  <= idx_reg;
            end
            if (!status.scan_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        if (cmd.emit)
        begin
            out_sum_reg   <= blk_sum_reg;
            out_temp_reg  <= temp_calc;
            out_in_reg    <= range_ok;
            out_shown_reg <= show_calc;
        end
    end

    assign done        = done_reg;
    assign block_sum   = out_sum_reg;
    assign temp_tenths = out_temp_reg;
    assign in_table    = out_in_reg;
    assign shown       = out_shown_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountLast)
        else $error("Sample count left its block range.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held for more than one cycle.");

    a_out_of_table: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_table) |-> (temp_tenths == '0 && !shown))
        else $error("Out-of-table result carries a temperature.");

    a_shown_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (done && shown) |-> in_table)
        else $error("Shown flag set outside the table.");

endmodule

>>> src/thermistor_block_average_to_temp.sv
// Top level of the thermistor block averager and temperature lookup.
// Instantiates tbat_ctrl and tbat_datapath; depends on tbat_pkg.
`timescale 1ns / 1ps

//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  sample    | start, busy          | adc_sample
//  result    | done (one cycle)     | block_sum, temp_tenths, in_table, shown
//  config    | cfg_valid, cfg_ready | cfg_index, cfg_data
//
//  Nine of every ten samples are taken in one cycle each and give no result.
//  The tenth starts a scan of the calibration ROM, one entry per cycle, over
//  TABLE_ENTRIES entries (capped at the 141 entries held); busy stays high
//  through the scan and the output state, and done pulses in the first cycle
//  after busy falls. Reset clears the sample block and loads the show limits
//  with 320 and 420. The receiver cannot stall.

module thermistor_block_average_to_temp
#(
    parameter int unsigned TABLE_ENTRIES = 141
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tbat_pkg::SampleW-1:0]  adc_sample,
    output logic                          done,
    output logic [tbat_pkg::SumW-1:0]     block_sum,
    output logic [tbat_pkg::TempW-1:0]    temp_tenths,
    output logic                          in_table,
    output logic                          shown,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [tbat_pkg::LimitW-1:0]   cfg_data
);

    tbat_pkg::tbat_cmd_t    cmd;
    tbat_pkg::tbat_status_t status;

    assign cfg_ready = 1'b1;

    tbat_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    tbat_datapath
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .adc_sample  (adc_sample),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .block_sum   (block_sum),
        .temp_tenths (temp_tenths),
        .in_table    (in_table),
        .shown       (shown)
    );

endmodule

>>> dv/tb.sv
// Testbench for thermistor_block_average_to_temp: drives ten-sample blocks, some
// directed, most random, and checks results against its predictor or typed values.
// Depends on tbat_pkg and the thermistor_block_average_to_temp RTL.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned TableLen    = 141;
    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned DrainCycles = 160;
    localparam int unsigned Phases      = 10;
    localparam int unsigned PhaseBlocks = 13;
    localparam int unsigned SampleMax   = (1 << tbat_pkg::SampleW) - 1;

    typedef struct packed {
        logic [tbat_pkg::SumW-1:0]  sum;
        logic [tbat_pkg::TempW-1:0] temp;
        logic                       in_tab;
        logic                       shown;
    } block_temp_t;

    typedef struct {
        int unsigned sum;
        bit          typed;
        block_temp_t want;
    } temp_row_t;

    logic                          clk        = 1'b0;
    logic                          rst_n      = 1'b0;
    logic                          start      = 1'b0;
    logic [tbat_pkg::SampleW-1:0]  adc_sample = '0;
    logic                          cfg_valid  = 1'b0;
    logic                          cfg_index  = tbat_pkg::REG_SHOW_LOW;
    logic [tbat_pkg::LimitW-1:0]   cfg_data   = '0;
    logic                          busy;
    logic                          done;
    logic [tbat_pkg::SumW-1:0]     block_sum;
    logic [tbat_pkg::TempW-1:0]    temp_tenths;
    logic                          in_table;
    logic                          shown;
    logic                          cfg_ready;

    block_temp_t                   pending_temps [$];
    logic [tbat_pkg::LimitW-1:0]   show_lo   = 10'd320;
    logic [tbat_pkg::LimitW-1:0]   show_hi   = 10'd420;
    logic [tbat_pkg::CountW-1:0]   blk_count = '0;
    logic [tbat_pkg::SumW-1:0]     blk_acc   = '0;
    int unsigned                   err_count   = 0;
    int unsigned                   cycle_count = 0;
    bit                            no_idle     = 1'b0;

    thermistor_block_average_to_temp u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .adc_sample  (adc_sample),
        .done        (done),
        .block_sum   (block_sum),
        .temp_tenths (temp_tenths),
        .in_table    (in_table),
        .shown       (shown),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit average_and_lookup(input logic [tbat_pkg::SampleW-1:0] s,
                                              output block_temp_t r);
        int unsigned n;
        int unsigned best;
        int unsigned best_d;
        int unsigned d;
        r = '0;
        blk_acc = blk_acc + tbat_pkg::SumW'(s);
        if (blk_count + 1 < tbat_pkg::BlockLen)
        begin
            blk_count = blk_count + 1'b1;
            return 1'b0;
        end
        r.sum = blk_acc;
        blk_acc = '0;
        blk_count = '0;
        n = (TableLen > tbat_pkg::RomHeld) ? tbat_pkg::RomHeld : TableLen;
        if (r.sum >= tbat_pkg::CAL_ROM[0] && r.sum <= tbat_pkg::CAL_ROM[n-1])
        begin
            best = 0;
            best_d = 32'hFFFF_FFFF;
            for (int i = 0; i < n; i++)
            begin
                d = (r.sum >= tbat_pkg::CAL_ROM[i]) ? 32'(r.sum - tbat_pkg::CAL_ROM[i])
                                                    : 32'(tbat_pkg::CAL_ROM[i] - r.sum);
                if (d < best_d)
                begin
                    best_d = d;
                    best = i;
                end
            end
            r.in_tab = 1'b1;
            r.temp = tbat_pkg::TempW'(tbat_pkg::TempBase + best);
            r.shown = (r.temp > show_lo) && (r.temp < show_hi);
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want,
                 $realtime);
    endtask

    always @(posedge clk)
    begin
        block_temp_t want;
        if (rst_n && done)
        begin
            if (pending_temps.size() == 0)
                report_mismatch("result with no request pending", 1, 0);
            else
            begin
                want = pending_temps.pop_front();
                if (block_sum !== want.sum)
                    report_mismatch("block_sum", block_sum, want.sum);
                if (temp_tenths !== want.temp)
                    report_mismatch("temp_tenths", temp_tenths, want.temp);
                if (in_table !== want.in_tab)
                    report_mismatch("in_table", in_table, want.in_tab);
                if (shown !== want.shown)
                    report_mismatch("shown", shown, want.shown);
            end
        end
    end

    task automatic send_sample(input logic [tbat_pkg::SampleW-1:0] s, input bit typed,
                               input block_temp_t want);
        block_temp_t r;
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(11, 0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        adc_sample <= s;
        @(negedge clk);
        while (busy) @(negedge clk);
        @(posedge clk);
        if (average_and_lookup(s, r))
            pending_temps.push_back(typed ? want : r);
    endtask

    task automatic send_block_sum(input int unsigned total, input bit even,
                                  input bit typed, input block_temp_t want);
        int unsigned left;
        int unsigned slots;
        int unsigned lo;
        int unsigned hi;
        int unsigned s;
        left = total;
        for (int k = 0; k < tbat_pkg::BlockLen; k++)
        begin
            slots = tbat_pkg::BlockLen - k;
            if (even)
                s = total / tbat_pkg::BlockLen
                    + ((k < total % tbat_pkg::BlockLen) ? 1 : 0);
            else
            begin
                lo = (left > SampleMax * (slots - 1)) ? left - SampleMax * (slots - 1) : 0;
                hi = (left < SampleMax) ? left : SampleMax;
                s = $urandom_range(hi, lo);
            end
            left -= s;
            send_sample(s[tbat_pkg::SampleW-1:0], typed, want);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_temps.size() > 0) @(posedge clk);
    endtask

    task automatic settle();
        drain_results();
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_limits(input logic [tbat_pkg::LimitW-1:0] lo,
                                input logic [tbat_pkg::LimitW-1:0] hi);
        cfg_valid <= 1'b1;
        for (int r = 0; r < 2; r++)
        begin
            cfg_index <= (r == 0) ? tbat_pkg::REG_SHOW_LOW : tbat_pkg::REG_SHOW_HIGH;
            cfg_data <= (r == 0) ? lo : hi;
            @(negedge clk);
            while (!cfg_ready) @(negedge clk);
            @(posedge clk);
            if (r == 0)
                show_lo = lo;
            else
                show_hi = hi;
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        temp_row_t   rows [13];
        block_temp_t none;
        int unsigned phase_lo [Phases];
        int unsigned phase_hi [Phases];
        int unsigned mode;
        int unsigned total;
        int unsigned idx;
        none = '0;
        rows = '{
            '{0,     1'b1, '{16'd0,     9'd0,   1'b0, 1'b0}},
            '{1579,  1'b1, '{16'd1579,  9'd0,   1'b0, 1'b0}},
            '{1580,  1'b1, '{16'd1580,  9'd300, 1'b1, 1'b0}},
            '{7258,  1'b1, '{16'd7258,  9'd320, 1'b1, 1'b0}},
            '{7259,  1'b0, '0},
            '{12640, 1'b1, '{16'd12640, 9'd340, 1'b1, 1'b1}},
            '{28930, 1'b0, '0},
            '{33947, 1'b0, '0},
            '{34210, 1'b0, '0},
            '{39390, 1'b1, '{16'd39390, 9'd440, 1'b1, 1'b0}},
            '{39391, 1'b1, '{16'd39391, 9'd0,   1'b0, 1'b0}},
            '{40950, 1'b1, '{16'd40950, 9'd0,   1'b0, 1'b0}},
            '{20000, 1'b0, '0}
        };
        phase_lo = '{0, 1023, 400, 350, 1023, 0, 299, 0, 0, 0};
        phase_hi = '{1023, 0, 401, 352, 1023, 0, 441, 0, 0, 0};
        for (int p = 7; p < Phases; p++)
        begin
            phase_lo[p] = (p == 9) ? $urandom_range(1023, 0) : $urandom_range(460, 280);
            phase_hi[p] = (p == 9) ? $urandom_range(1023, 0) : $urandom_range(460, 280);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_block_sum(rows[i].sum, 1'b1, rows[i].typed, rows[i].want);

        for (int p = 0; p < Phases; p++)
        begin
            settle();
            write_limits(tbat_pkg::LimitW'(phase_lo[p]), tbat_pkg::LimitW'(phase_hi[p]));
            no_idle = (p % 2 == 1);
            repeat (PhaseBlocks)
            begin
                if ($urandom_range(15, 0) == 0)
                    drain_results();
                mode = $urandom_range(9, 0);
                if (mode <= 1)
                    repeat (tbat_pkg::BlockLen)
                        send_sample(tbat_pkg::SampleW'($urandom_range(SampleMax, 0)),
                                    1'b0, none);
                else
                begin
                    case (mode) inside
                        2, 3:    total = $urandom_range(40950, 0);
                        4, 5, 6:
                        begin
                            idx = $urandom_range(tbat_pkg::RomHeld - 1, 0);
                            total = tbat_pkg::CAL_ROM[idx] + $urandom_range(6, 0) - 3;
                        end
                        7:
                        begin
                            idx = $urandom_range(tbat_pkg::RomHeld - 2, 0);
                            total = (tbat_pkg::CAL_ROM[idx] + tbat_pkg::CAL_ROM[idx+1]) / 2
                                    + $urandom_range(1, 0);
                        end
                        8:
                        begin
                            idx = $urandom_range(7, 0);
                            total = (idx < 4) ? 1578 + idx : 39389 + idx - 4;
                        end
                        default: total = $urandom_range(39390, 1580);
                    endcase
                    send_block_sum(total, 1'b0, 1'b0, none);
                end
            end
        end

        settle();
        if (err_count == 0 && pending_temps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CycleLimit);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
